// ----- hw/rtl/tmgar_pkg.sv -----
`timescale 1ns / 1ps

package tmgar_pkg;

    // Geometry and widths fixed by the field formats
    localparam int ROM_DEPTH        = 4096;
    localparam int ROM_AW           = 12;
    localparam int OFF_W            = 12;   // cell offset, row * columns + column
    localparam int SUM_W            = 15;   // start address plus offset before wrapping
    localparam int CFG_W            = 14;
    localparam int CFG_IDX_W        = 3;
    localparam int S_TDATA_W        = 40;
    localparam int S_TUSER_W        = 4;
    localparam int M_TDATA_W        = 32;
    localparam int M_TUSER_W        = 1;

    localparam int DEF_RAM_DEPTH    = 2048;
    localparam int DEF_TEXT_COLUMNS = 80;

    // Request kinds
    localparam logic [2:0] KIND_RAM_WR     = 3'd0;
    localparam logic [2:0] KIND_RAM_RD     = 3'd1;
    localparam logic [2:0] KIND_ROM_LOAD   = 3'd2;
    localparam logic [2:0] KIND_FIELD_TICK = 3'd3;
    localparam logic [2:0] KIND_SYNC_CLR   = 3'd4;
    localparam logic [2:0] KIND_RENDER     = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_START = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_ADDR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_FIRST = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_LAST  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_MODE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_EXT_ROM      = 3'd5;

    // Cursor blink modes
    localparam logic [1:0] BLINK_SOLID = 2'd0;
    localparam logic [1:0] BLINK_FAST  = 2'd1;
    localparam logic [1:0] BLINK_SLOW  = 2'd2;

    // Glue codes, attribute bits 6..4
    localparam logic [2:0] GLUE_PLAIN      = 3'd0;
    localparam logic [2:0] GLUE_UNDERLINE  = 3'd1;
    localparam logic [2:0] GLUE_BLINK_UL   = 3'd2;
    localparam logic [2:0] GLUE_OVERLINE   = 3'd3;
    localparam logic [2:0] GLUE_HIDE       = 3'd4;
    localparam logic [2:0] GLUE_OVER_UNDER = 3'd5;
    localparam logic [2:0] GLUE_UPPER_HALF = 3'd6;
    localparam logic [2:0] GLUE_LOWER_HALF = 3'd7;

    localparam logic [3:0] UNDERLINE_LINE  = 4'hd;
    localparam logic [3:0] OVERLINE_LINE   = 4'h0;
    localparam logic [3:0] LOWER_BASE_LINE = 4'd7;
    localparam logic [3:0] LOWER_LAST_LINE = 4'd12;

    // Attribute bit positions
    localparam int ATTR_INVERT = 0;
    localparam int ATTR_BLINK  = 1;
    localparam int ATTR_DOUBLE = 3;
    localparam int ATTR_EXT    = 7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADDR,
        ST_WRAP,
        ST_MEM,
        ST_ROM,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load_in;
        logic load_addr;
        logic wrap_step;
        logic mem_op;
        logic rom_rd;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] kind;
        logic       addr_ge_depth;
    } dp_stat_t;

endpackage

// ----- hw/rtl/tmgar_ctrl.sv -----
`timescale 1ns / 1ps

module tmgar_ctrl import tmgar_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_ADDR;
                end
            end
            ST_ADDR: begin
                cmd.load_addr = 1'b1;
                state_next    = ST_WRAP;
            end
            ST_WRAP: begin
                // subtract the depth until the address falls inside the RAM
                if (stat.addr_ge_depth) begin
                    cmd.wrap_step = 1'b1;
                end else begin
                    state_next = ST_MEM;
                end
            end
            ST_MEM: begin
                cmd.mem_op = 1'b1;
                state_next = (stat.kind == KIND_RENDER) ? ST_ROM : ST_DONE;
            end
            ST_ROM: begin
                cmd.rom_rd = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        if (cmd.load_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

// ----- hw/rtl/tmgar_datapath.sv -----
`timescale 1ns / 1ps

module tmgar_datapath import tmgar_pkg::*; #(
    parameter int RAM_DEPTH    = DEF_RAM_DEPTH,
    parameter int TEXT_COLUMNS = DEF_TEXT_COLUMNS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dp_cmd_t              cmd,
    output dp_stat_t             stat,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [S_TUSER_W-1:0] s_tuser,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [M_TUSER_W-1:0] m_tuser
);

    localparam int RAM_AW = $clog2(RAM_DEPTH);

    // Latched request
    logic [2:0]  kind_reg;
    logic        bank_reg;
    logic [11:0] address_reg;
    logic [7:0]  data_reg;
    logic [4:0]  row_reg;
    logic [6:0]  column_reg;
    logic [3:0]  line_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            kind_reg    <= s_tuser[2:0];
            bank_reg    <= s_tuser[3];
            address_reg <= s_tdata[11:0];
            data_reg    <= s_tdata[19:12];
            row_reg     <= s_tdata[24:20];
            column_reg  <= s_tdata[31:25];
            line_reg    <= s_tdata[35:32];
        end
    end

    // Configuration
    logic [CFG_W-1:0] screen_start_reg;
    logic [CFG_W-1:0] cursor_addr_reg;
    logic [3:0]       cursor_first_reg;
    logic [3:0]       cursor_last_reg;
    logic [1:0]       blink_mode_reg;
    logic             ext_rom_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            screen_start_reg <= '0;
            cursor_addr_reg  <= '0;
            cursor_first_reg <= 4'd0;
            cursor_last_reg  <= 4'd15;
            blink_mode_reg   <= BLINK_SOLID;
            ext_rom_reg      <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_SCREEN_START: screen_start_reg <= cfg_wdata;
                CFG_CURSOR_ADDR:  cursor_addr_reg  <= cfg_wdata;
                CFG_CURSOR_FIRST: cursor_first_reg <= cfg_wdata[3:0];
                CFG_CURSOR_LAST:  cursor_last_reg  <= cfg_wdata[3:0];
                CFG_BLINK_MODE:   blink_mode_reg   <= cfg_wdata[1:0];
                CFG_EXT_ROM:      ext_rom_reg      <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Cell offset and RAM address
    logic [OFF_W-1:0] off_reg, off_next;
    logic [SUM_W-1:0] addr_reg;
    logic [RAM_AW-1:0] ram_addr;

    assign off_next = OFF_W'(row_reg) * OFF_W'(TEXT_COLUMNS) + OFF_W'(column_reg);

    always_ff @(posedge aclk) begin
        if (cmd.load_addr) begin
            off_reg <= off_next;
            if (kind_reg == KIND_RENDER) begin
                addr_reg <= SUM_W'(screen_start_reg) + SUM_W'(off_next);
            end else begin
                addr_reg <= SUM_W'(address_reg);
            end
        end else if (cmd.wrap_step) begin
            addr_reg <= addr_reg - SUM_W'(RAM_DEPTH);
        end
    end

    assign ram_addr           = addr_reg[RAM_AW-1:0];
    assign stat.kind          = kind_reg;
    assign stat.addr_ge_depth = (addr_reg >= SUM_W'(RAM_DEPTH));

    // Character and attribute RAMs
    logic [7:0] char_mem [RAM_DEPTH];
    logic [7:0] attr_mem [RAM_DEPTH];
    logic [7:0] char_rd_reg;
    logic [7:0] attr_rd_reg;
    logic       ram_wr;

    assign ram_wr = cmd.mem_op && (kind_reg == KIND_RAM_WR);

    always_ff @(posedge aclk) begin
        if (ram_wr && !bank_reg) begin
            char_mem[ram_addr] <= data_reg;
        end
        if (cmd.mem_op) begin
            char_rd_reg <= char_mem[ram_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (ram_wr && bank_reg) begin
            attr_mem[ram_addr] <= data_reg;
        end
        if (cmd.mem_op) begin
            attr_rd_reg <= attr_mem[ram_addr];
        end
    end

    // Glyph ROMs
    logic [7:0]        std_rom [ROM_DEPTH];
    logic [7:0]        ext_rom [ROM_DEPTH];
    logic [7:0]        std_rd_reg;
    logic [7:0]        ext_rd_reg;
    logic              rom_wr;
    logic [2:0]        glue;
    logic [3:0]        glyph_idx;
    logic [ROM_AW-1:0] rom_addr;

    assign rom_wr = cmd.mem_op && (kind_reg == KIND_ROM_LOAD);
    assign glue   = attr_rd_reg[6:4];

    always_comb begin
        unique case (glue)
            GLUE_UPPER_HALF: glyph_idx = {1'b0, line_reg[3:1]};
            GLUE_LOWER_HALF: glyph_idx = LOWER_BASE_LINE + {1'b0, line_reg[3:1]};
            default:         glyph_idx = line_reg;
        endcase
    end

    assign rom_addr = {char_rd_reg, glyph_idx};

    always_ff @(posedge aclk) begin
        if (rom_wr && !bank_reg) begin
            std_rom[address_reg] <= data_reg;
        end
        if (cmd.rom_rd) begin
            std_rd_reg <= std_rom[rom_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (rom_wr && bank_reg) begin
            ext_rom[address_reg] <= data_reg;
        end
        if (cmd.rom_rd) begin
            ext_rd_reg <= ext_rom[rom_addr];
        end
    end

    // Field phase and sync flag
    logic [4:0] field_phase_reg;
    logic       sync_seen_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            field_phase_reg <= '0;
            sync_seen_reg   <= 1'b0;
        end else if (cmd.mem_op) begin
            if (kind_reg == KIND_FIELD_TICK) begin
                field_phase_reg <= field_phase_reg + 5'd1;
                sync_seen_reg   <= 1'b1;
            end else if (kind_reg == KIND_SYNC_CLR) begin
                sync_seen_reg <= 1'b0;
            end
        end
    end

    // Pixel shaping
    logic             blink_dark;
    logic [7:0]       seg_rom, seg_glue, seg_shaped;
    logic [7:0]       wide_hi, wide_lo, first_px, second_px;
    logic             dbl;
    logic             phase_on, line_on;
    logic [CFG_W-1:0] cursor_diff;
    logic             hit_first, hit_second;

    assign blink_dark = !field_phase_reg[4];
    assign seg_rom    = (ext_rom_reg && attr_rd_reg[ATTR_EXT]) ? ext_rd_reg : std_rd_reg;

    always_comb begin
        seg_glue = seg_rom;
        unique case (glue)
            GLUE_PLAIN: ;
            GLUE_UNDERLINE: begin
                if (line_reg == UNDERLINE_LINE) seg_glue = 8'hff;
            end
            GLUE_BLINK_UL: begin
                if (line_reg == UNDERLINE_LINE) seg_glue = blink_dark ? 8'h00 : 8'hff;
            end
            GLUE_OVERLINE: begin
                if (line_reg == OVERLINE_LINE) seg_glue = 8'hff;
            end
            GLUE_HIDE: seg_glue = 8'h00;
            GLUE_OVER_UNDER: begin
                if (line_reg == OVERLINE_LINE || line_reg == UNDERLINE_LINE) begin
                    seg_glue = 8'hff;
                end
            end
            GLUE_UPPER_HALF: ;
            GLUE_LOWER_HALF: begin
                if (line_reg > LOWER_LAST_LINE) seg_glue = 8'h00;
            end
            default: ;
        endcase
    end

    always_comb begin
        seg_shaped = attr_rd_reg[ATTR_INVERT] ? ~seg_glue : seg_glue;
        if (attr_rd_reg[ATTR_BLINK] && blink_dark) begin
            seg_shaped = 8'h00;
        end
    end

    // Each glyph pixel becomes two screen pixels
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            wide_hi[2*k +: 2] = {2{seg_shaped[4+k]}};
            wide_lo[2*k +: 2] = {2{seg_shaped[k]}};
        end
    end

    assign dbl = attr_rd_reg[ATTR_DOUBLE];

    always_comb begin
        unique case (blink_mode_reg)
            BLINK_FAST: phase_on = !field_phase_reg[3];
            BLINK_SLOW: phase_on = !field_phase_reg[4];
            default:    phase_on = 1'b1;
        endcase
    end

    assign line_on     = (line_reg >= cursor_first_reg) && (line_reg <= cursor_last_reg);
    assign cursor_diff = cursor_addr_reg - screen_start_reg;
    assign hit_first   = phase_on && line_on && (CFG_W'(off_reg) == cursor_diff);
    assign hit_second  = phase_on && line_on && dbl
                         && ((CFG_W'(off_reg) + CFG_W'(1)) == cursor_diff)
                         && (({1'b0, column_reg} + 8'd1) < 8'(TEXT_COLUMNS));

    assign first_px  = (dbl ? wide_hi : seg_shaped) ^ {8{hit_first}};
    assign second_px = (dbl ? wide_lo : 8'h00) ^ {8{hit_second}};

    // Result register
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [M_TUSER_W-1:0] m_tuser_reg, m_tuser_next;
    logic [7:0]           read_byte;

    assign read_byte = bank_reg ? attr_rd_reg : char_rd_reg;

    always_comb begin
        m_tdata_next     = '0;
        m_tuser_next     = '0;
        m_tdata_next[24] = sync_seen_reg;
        if (kind_reg == KIND_RAM_RD) begin
            m_tdata_next[7:0] = read_byte;
        end
        if (kind_reg == KIND_RENDER) begin
            m_tdata_next[15:8]  = first_px;
            m_tdata_next[23:16] = second_px;
            m_tuser_next[0]     = dbl;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;

endmodule

// ----- hw/rtl/text_mode_glyph_attribute_renderer.sv -----
`timescale 1ns / 1ps

// Text-mode glyph renderer: character and attribute RAMs, standard and
// extended glyph ROMs, and the pixel shaping for one scanline of one cell.
// Requests arrive on the s_ stream (kind and bank in s_tuser); each one
// yields exactly one result on the m_ stream. RAM writes, RAM reads, ROM
// loads, field ticks, sync clears and renders all share the one channel.
// Configuration registers are written through cfg_we / cfg_index /
// cfg_wdata; the user must write them only while no request is in
// flight, as the block itself does not enforce this. Once accepted, a
// request passes through the controller states address load, address
// wrap, RAM access, ROM read (renders only) and result load, in that
// order; the wrap subtracts the RAM depth until the address lies below it
// (none below the depth, at most 9 times for a render near the top of the
// start-address range). The next request can be accepted the cycle after
// the result load. A stalled receiver holds the result register; the block
// then finishes the next request up to its result and waits there.
// Reset clears the configuration to its defaults, the field phase and the
// sync flag; RAM and ROM contents stay undefined until written.
module text_mode_glyph_attribute_renderer import tmgar_pkg::*; #(
    parameter int RAM_DEPTH    = DEF_RAM_DEPTH,
    parameter int TEXT_COLUMNS = DEF_TEXT_COLUMNS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // address[11:0], data[19:12], row[24:20], column[31:25], scanline[35:32]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // kind[2:0], bank[3]
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // read_data[7:0], pixels_first[15:8], pixels_second[23:16], sync_flag[24]
    output logic [M_TDATA_W-1:0] m_tdata,
    // doubled[0]
    output logic [M_TUSER_W-1:0] m_tuser,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    tmgar_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tmgar_datapath #(
        .RAM_DEPTH    (RAM_DEPTH),
        .TEXT_COLUMNS (TEXT_COLUMNS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // One request at a time: no back-to-back acceptance
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while another is in flight");

    // The right-hand byte only carries pixels when the cell is doubled
    a_second_needs_double: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[23:16] == 8'h00))
        else $error("second pixel byte set on an undoubled result");

    // A result is either a RAM read or a render, never both
    a_read_or_render: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:0] == 8'h00 || m_tdata[15:8] == 8'h00))
        else $error("read data and pixels both present");

    // A result is only loaded from the final controller step
    a_load_in_done: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!cmd.load_in && !cmd.mem_op && !cmd.rom_rd))
        else $error("result loaded outside the final step");

endmodule

// ----- tb/tb_text_mode_glyph_attribute_renderer.sv -----
`timescale 1ns / 1ps

module tb_text_mode_glyph_attribute_renderer;
    import tmgar_pkg::*;

    localparam int RAM_DEPTH    = DEF_RAM_DEPTH;
    localparam int TEXT_COLUMNS = DEF_TEXT_COLUMNS;
    localparam int TEXT_ROWS    = 25;
    localparam int MAX_OFFSET   = 31 * TEXT_COLUMNS + 127;
    localparam int DRAIN_CYCLES = 20;
    localparam int TIMEOUT_NS   = 5_000_000;

    localparam logic [2:0] KIND_SPARE_6 = 3'd6;
    localparam logic [2:0] KIND_SPARE_7 = 3'd7;
    localparam logic [1:0] BLINK_SPARE  = 2'd3;

    typedef struct {
        logic [2:0]  kind;
        logic        bank;
        logic [11:0] address;
        logic [7:0]  data;
        logic [4:0]  row;
        logic [6:0]  column;
        logic [3:0]  scanline;
    } request_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] pix_first;
        logic [7:0] pix_second;
        logic       doubled;
        logic       sync_flag;
    } cell_result_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [S_TUSER_W-1:0] s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    // Shadow of the display state
    logic [7:0]  char_mem  [RAM_DEPTH];
    logic [7:0]  attr_mem  [RAM_DEPTH];
    logic [7:0]  glyph_mem [2][ROM_DEPTH];
    bit          char_set  [RAM_DEPTH];
    bit          attr_set  [RAM_DEPTH];
    bit          glyph_set [2][ROM_DEPTH];
    logic [4:0]  phase_ctr    = '0;
    logic        sync_bit     = 1'b0;
    logic [13:0] start_addr   = '0;
    logic [13:0] cursor_addr  = '0;
    logic [3:0]  cursor_first = 4'd0;
    logic [3:0]  cursor_last  = 4'd15;
    logic [1:0]  blink_mode   = BLINK_SOLID;
    logic        ext_fitted   = 1'b0;

    logic [7:0] glyph_pool [12] = '{8'h00, 8'hff, 8'h80, 8'h7f, 8'h41, 8'h5a,
                                    8'hc3, 8'h3c, 8'h01, 8'hfe, 8'h18, 8'he7};

    cell_result_t outputs_due[$];
    int           mismatch_count = 0;
    int           stall_left     = 0;
    bit           idling_on      = 1'b1;

    text_mode_glyph_attribute_renderer #(
        .RAM_DEPTH    (RAM_DEPTH),
        .TEXT_COLUMNS (TEXT_COLUMNS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    function automatic cell_result_t renderer_step(input request_t r);
        cell_result_t o;
        int           off, ram_a;
        logic [7:0]   char_b, attr_b, seg;
        logic [15:0]  wide;
        logic [13:0]  cur_diff;
        logic         ext_sel, shown;
        o = '0;
        case (r.kind)
            KIND_RAM_WR: begin
                if (r.bank) begin
                    attr_mem[r.address % RAM_DEPTH] = r.data;
                    attr_set[r.address % RAM_DEPTH] = 1'b1;
                end else begin
                    char_mem[r.address % RAM_DEPTH] = r.data;
                    char_set[r.address % RAM_DEPTH] = 1'b1;
                end
            end
            KIND_RAM_RD: begin
                o.read_data = r.bank ? attr_mem[r.address % RAM_DEPTH]
                                     : char_mem[r.address % RAM_DEPTH];
            end
            KIND_ROM_LOAD: begin
                glyph_mem[r.bank][r.address] = r.data;
                glyph_set[r.bank][r.address] = 1'b1;
            end
            KIND_FIELD_TICK: begin
                phase_ctr = phase_ctr + 5'd1;
                sync_bit  = 1'b1;
            end
            KIND_SYNC_CLR: sync_bit = 1'b0;
            KIND_RENDER: begin
                off     = r.row * TEXT_COLUMNS + r.column;
                ram_a   = (start_addr + off) % RAM_DEPTH;
                char_b  = char_mem[ram_a];
                attr_b  = attr_mem[ram_a];
                ext_sel = ext_fitted && attr_b[ATTR_EXT];
                seg     = glyph_mem[ext_sel][{char_b, r.scanline}];
                case (attr_b[6:4])
                    GLUE_UNDERLINE:
                        if (r.scanline == UNDERLINE_LINE) seg = 8'hff;
                    GLUE_BLINK_UL:
                        if (r.scanline == UNDERLINE_LINE) seg = (phase_ctr < 16) ? 8'h00 : 8'hff;
                    GLUE_OVERLINE:
                        if (r.scanline == OVERLINE_LINE) seg = 8'hff;
                    GLUE_HIDE:
                        seg = 8'h00;
                    GLUE_OVER_UNDER:
                        if (r.scanline == OVERLINE_LINE || r.scanline == UNDERLINE_LINE)
                            seg = 8'hff;
                    GLUE_UPPER_HALF:
                        seg = glyph_mem[ext_sel][{char_b, 1'b0, r.scanline[3:1]}];
                    GLUE_LOWER_HALF:
                        seg = (r.scanline <= LOWER_LAST_LINE)
                            ? glyph_mem[ext_sel][{char_b, 4'(LOWER_BASE_LINE + r.scanline[3:1])}]
                            : 8'h00;
                    default: ;
                endcase
                if (attr_b[ATTR_INVERT])
                    seg = ~seg;
                if (attr_b[ATTR_BLINK] && phase_ctr < 16)
                    seg = 8'h00;
                if (attr_b[ATTR_DOUBLE]) begin
                    wide = '0;
                    for (int b = 0; b < 8; b++)
                        if (seg[b])
                            wide[2*b +: 2] = 2'b11;
                    o.pix_first  = wide[15:8];
                    o.pix_second = wide[7:0];
                    o.doubled    = 1'b1;
                end else begin
                    o.pix_first = seg;
                end
                case (blink_mode)
                    BLINK_FAST: shown = (phase_ctr % 16) < 8;
                    BLINK_SLOW: shown = phase_ctr < 16;
                    default:    shown = 1'b1;
                endcase
                if (shown && r.scanline >= cursor_first && r.scanline <= cursor_last) begin
                    cur_diff = cursor_addr - start_addr;
                    if (off == cur_diff)
                        o.pix_first = ~o.pix_first;
                    if (o.doubled && off + 1 == cur_diff && r.column + 1 < TEXT_COLUMNS)
                        o.pix_second = ~o.pix_second;
                end
            end
            default: ;
        endcase
        o.sync_flag = sync_bit;
        return o;
    endfunction

    function automatic request_t random_request(input logic [2:0] kind);
        request_t r;
        r.kind     = kind;
        r.bank     = 1'($urandom);
        r.address  = 12'($urandom);
        r.data     = 8'($urandom);
        r.row      = 5'($urandom);
        r.column   = 7'($urandom);
        r.scanline = 4'($urandom);
        return r;
    endfunction

    function automatic logic [7:0] pool_char();
        return glyph_pool[$urandom_range(0, 11)];
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("%0t: mismatch on %s: got %02h, want %02h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_request(input request_t r);
        if (idling_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        outputs_due.push_back(renderer_step(r));
        s_tdata  <= {4'b0, r.scanline, r.column, r.row, r.data, r.address};
        s_tuser  <= {r.bank, r.kind};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic ram_write(input logic bank, input logic [11:0] address,
                             input logic [7:0] data);
        request_t r;
        r = random_request(KIND_RAM_WR);
        r.bank    = bank;
        r.address = address;
        r.data    = data;
        send_request(r);
    endtask

    task automatic ram_read(input logic bank, input logic [11:0] address);
        request_t r;
        r = random_request(KIND_RAM_RD);
        r.bank    = bank;
        r.address = address;
        send_request(r);
    endtask

    task automatic rom_load(input logic bank, input logic [11:0] address,
                            input logic [7:0] data);
        request_t r;
        r = random_request(KIND_ROM_LOAD);
        r.bank    = bank;
        r.address = address;
        r.data    = data;
        send_request(r);
    endtask

    task automatic render_cell(input logic [4:0] row, input logic [6:0] column,
                               input logic [3:0] scanline);
        request_t r;
        r = random_request(KIND_RENDER);
        r.row      = row;
        r.column   = column;
        r.scanline = scanline;
        send_request(r);
    endtask

    // Fill whatever a render of this cell reads: character, attribute and every
    // line of its glyph in both ROMs.
    task automatic prepare_cell(input logic [4:0] row, input logic [6:0] column,
                                input bit fresh_attr);
        int         ram_a;
        logic [7:0] char_b;
        ram_a = (start_addr + row * TEXT_COLUMNS + column) % RAM_DEPTH;
        if (!char_set[ram_a])
            ram_write(1'b0, 12'(ram_a + RAM_DEPTH * $urandom_range(0, 1)), pool_char());
        if (!attr_set[ram_a] || fresh_attr)
            ram_write(1'b1, 12'(ram_a + RAM_DEPTH * $urandom_range(0, 1)), 8'($urandom));
        char_b = char_mem[ram_a];
        for (int b = 0; b < 2; b++)
            for (int l = 0; l < 16; l++)
                if (!glyph_set[b][{char_b, 4'(l)}])
                    rom_load(b == 1, {char_b, 4'(l)}, 8'($urandom));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
    endtask

    task automatic configure_display(input logic [13:0] scr_start, input logic [13:0] cur_addr,
                                     input logic [3:0] first, input logic [3:0] last,
                                     input logic [1:0] mode, input logic ext);
        write_reg(CFG_SCREEN_START, scr_start);
        write_reg(CFG_CURSOR_ADDR, cur_addr);
        write_reg(CFG_CURSOR_FIRST, CFG_W'(first));
        write_reg(CFG_CURSOR_LAST, CFG_W'(last));
        write_reg(CFG_BLINK_MODE, CFG_W'(mode));
        write_reg(CFG_EXT_ROM, CFG_W'(ext));
        cfg_we       <= 1'b0;
        start_addr   = scr_start;
        cursor_addr  = cur_addr;
        cursor_first = first;
        cursor_last  = last;
        blink_mode   = mode;
        ext_fitted   = ext;
    endtask

    // Drop valid, then let the pipeline empty before touching the registers.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (outputs_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic run_traffic(input int count);
        int          pick, target;
        logic [13:0] cur_diff;
        logic [4:0]  row;
        logic [6:0]  column;
        logic        bank;
        logic [11:0] address;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            bank = 1'($urandom);
            address = 12'($urandom);
            if (pick < 55) begin
                cur_diff = cursor_addr - start_addr;
                target   = int'(cur_diff) - int'($urandom_range(0, 1));
                pick     = $urandom_range(0, 9);
                if (pick < 3 && target >= 0 && target <= MAX_OFFSET) begin
                    // aim at the cursor cell or the one to its left
                    row    = (target / TEXT_COLUMNS > 31) ? 5'd31 : 5'(target / TEXT_COLUMNS);
                    column = 7'(target - row * TEXT_COLUMNS);
                end else if (pick == 3) begin
                    row    = 5'($urandom);
                    column = 7'($urandom);
                end else begin
                    row    = 5'($urandom_range(0, TEXT_ROWS - 1));
                    column = 7'($urandom_range(0, TEXT_COLUMNS - 1));
                end
                prepare_cell(row, column, $urandom_range(0, 3) == 0);
                render_cell(row, column, 4'($urandom));
            end else if (pick < 67) begin
                send_request(random_request(KIND_FIELD_TICK));
            end else if (pick < 72) begin
                send_request(random_request(KIND_SYNC_CLR));
            end else if (pick < 82) begin
                if (!(bank ? attr_set[address % RAM_DEPTH] : char_set[address % RAM_DEPTH]))
                    ram_write(bank, address ^ 12'h800, bank ? 8'($urandom) : pool_char());
                ram_read(bank, address);
            end else if (pick < 90) begin
                ram_write(bank, address, bank ? 8'($urandom) : pool_char());
            end else if (pick < 96) begin
                rom_load(bank, address, 8'($urandom));
            end else begin
                send_request(random_request(bank ? KIND_SPARE_7 : KIND_SPARE_6));
            end
        end
    endtask

    task automatic test_field_and_sync();
        send_request(random_request(KIND_SYNC_CLR));
        send_request(random_request(KIND_FIELD_TICK));
        send_request(random_request(KIND_FIELD_TICK));
        send_request(random_request(KIND_SPARE_6));
        send_request(random_request(KIND_SPARE_7));
        send_request(random_request(KIND_SYNC_CLR));
        send_request(random_request(KIND_FIELD_TICK));
        wait_drained();
    endtask

    task automatic test_memory_access();
        ram_write(1'b0, 12'h000, 8'h00);
        ram_write(1'b1, 12'hfff, 8'hff);
        ram_write(1'b0, 12'h7ff, 8'h5a);
        ram_write(1'b1, 12'h800, 8'ha5);
        ram_read(1'b0, 12'h800);
        ram_read(1'b1, 12'h7ff);
        ram_read(1'b0, 12'hfff);
        ram_read(1'b1, 12'h000);
        rom_load(1'b0, 12'h000, 8'hff);
        rom_load(1'b1, 12'hfff, 8'h00);
        wait_drained();
    endtask

    task automatic test_glyph_effects();
        logic [2:0] glue;
        configure_display(14'd0, 14'h3fff, 4'd0, 4'd15, BLINK_SOLID, 1'b1);
        ram_write(1'b0, 12'd1, 8'hc3);
        prepare_cell(5'd0, 7'd1, 1'b0);
        for (int g = GLUE_PLAIN; g <= GLUE_LOWER_HALF; g++) begin
            glue = 3'(g);
            ram_write(1'b1, 12'd1, {glue[0], glue, 4'b0000});
            render_cell(5'd0, 7'd1, OVERLINE_LINE);
            render_cell(5'd0, 7'd1, UNDERLINE_LINE);
        end
        ram_write(1'b1, 12'd1, 8'h01);
        render_cell(5'd0, 7'd1, 4'd3);
        ram_write(1'b1, 12'd1, 8'h02);
        render_cell(5'd0, 7'd1, 4'd3);
        ram_write(1'b1, 12'd1, 8'h04);
        render_cell(5'd0, 7'd1, 4'd3);
        ram_write(1'b1, 12'd1, 8'h8f);
        render_cell(5'd0, 7'd1, 4'd15);
        wait_drained();
    endtask

    task automatic test_cursor();
        configure_display(14'd0, 14'd1, 4'd2, 4'd6, BLINK_SOLID, 1'b1);
        render_cell(5'd0, 7'd1, 4'd2);
        prepare_cell(5'd0, 7'd0, 1'b0);
        ram_write(1'b1, 12'd0, 8'h08);
        render_cell(5'd0, 7'd0, 4'd6);
        render_cell(5'd0, 7'd0, 4'd7);
        prepare_cell(5'd0, 7'd79, 1'b0);
        prepare_cell(5'd1, 7'd0, 1'b0);
        ram_write(1'b1, 12'd79, 8'h08);
        wait_drained();
        // cursor just past the end of row 0: no right-half hit from the last column
        configure_display(14'd0, 14'd80, 4'd0, 4'd15, BLINK_SOLID, 1'b0);
        render_cell(5'd0, 7'd79, 4'd4);
        render_cell(5'd0, 7'd80, 4'd4);
        render_cell(5'd1, 7'd0, 4'd4);
        wait_drained();
    endtask

    task automatic test_random_traffic();
        logic [13:0] scr_start, cur_addr;
        for (int p = 0; p < 6; p++) begin
            scr_start = 14'($urandom);
            cur_addr  = scr_start + 14'($urandom_range(0, MAX_OFFSET));
            case (p)
                0: configure_display(14'd0, 14'd0, 4'd0, 4'd15, BLINK_SOLID, 1'b0);
                1: configure_display(14'h3fff, 14'h3fff, 4'd15, 4'd15, BLINK_FAST, 1'b1);
                2: configure_display(scr_start, cur_addr, 4'd9, 4'd2, BLINK_SLOW, 1'b1);
                3: configure_display(scr_start, cur_addr, 4'($urandom), 4'($urandom),
                                     BLINK_SPARE, 1'b1);
                4: configure_display(14'd2047, 14'(2047 + $urandom_range(0, MAX_OFFSET)),
                                     4'd0, 4'd0, BLINK_FAST, 1'b0);
                default: configure_display(scr_start, cur_addr, 4'($urandom), 4'($urandom),
                                           2'($urandom), 1'($urandom));
            endcase
            run_traffic(40);
            wait_drained();
        end
    endtask

    task automatic test_unstalled_traffic();
        logic [13:0] scr_start;
        idling_on = 1'b0;
        scr_start = 14'($urandom);
        configure_display(scr_start, scr_start + 14'($urandom_range(0, MAX_OFFSET)),
                          4'($urandom_range(0, 7)), 4'($urandom_range(8, 15)),
                          2'($urandom), 1'b1);
        run_traffic(40);
        wait_drained();
    endtask

    always @(posedge aclk) begin : drive_tready
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (idling_on && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 13);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : check_results
        cell_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{read_data: m_tdata[7:0], pix_first: m_tdata[15:8],
                    pix_second: m_tdata[23:16], doubled: m_tuser[0],
                    sync_flag: m_tdata[24]};
            if (outputs_due.size() == 0) begin
                report_mismatch("unrequested result", got.pix_first, 8'h00);
            end else begin
                want = outputs_due.pop_front();
                if (got.read_data !== want.read_data)
                    report_mismatch("read_data", got.read_data, want.read_data);
                if (got.pix_first !== want.pix_first)
                    report_mismatch("pixels_first", got.pix_first, want.pix_first);
                if (got.pix_second !== want.pix_second)
                    report_mismatch("pixels_second", got.pix_second, want.pix_second);
                if (got.doubled !== want.doubled)
                    report_mismatch("doubled", 8'(got.doubled), 8'(want.doubled));
                if (got.sync_flag !== want.sync_flag)
                    report_mismatch("sync_flag", 8'(got.sync_flag), 8'(want.sync_flag));
            end
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_field_and_sync();
        test_memory_access();
        test_glyph_effects();
        test_cursor();
        test_random_traffic();
        test_unstalled_traffic();
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d results outstanding", outputs_due.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/tmgar_pkg.sv
hw/rtl/tmgar_ctrl.sv
hw/rtl/tmgar_datapath.sv
hw/rtl/text_mode_glyph_attribute_renderer.sv
tb/tb_text_mode_glyph_attribute_renderer.sv
